// ===== rtl/fird3_pkg.sv =====
// Shared types, constants and tap lookup for the 3:1 FIR decimator.
package fird3_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int HALF_N    = 24;
    localparam int FRAC_BITS = 15;
    localparam int ROUND_BIAS = 32'h0000_7fff;

    // First half of the symmetric low-pass taps; the second half mirrors it.
    localparam logic signed [SAMPLE_W-1:0] HALF_TAPS [HALF_N] = '{
        -16'sd20,   -16'sd39,   -16'sd21,   16'sd33,    16'sd77,    16'sd45,
        -16'sd72,   -16'sd169,  -16'sd98,   16'sd145,   16'sd335,   16'sd193,
        -16'sd268,  -16'sd613,  -16'sd353,  16'sd471,   16'sd1097,  16'sd649,
        -16'sd861,  -16'sd2134, -16'sd1393, 16'sd2064,  16'sd6903,  16'sd10412
    };

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic start;   // load rounding bias into the accumulator
        logic mul_en;  // multiply tap by the sample at the head of the chain
    } mac_ctl_t;

    // Tap k of the 48-tap set; zero at and beyond index 48
    function automatic logic signed [SAMPLE_W-1:0] tap_at(input int unsigned k);
        logic signed [SAMPLE_W-1:0] t;
        t = '0;
        if (k < HALF_N)
        begin
            t = HALF_TAPS[k];
        end
        else if (k < 2 * HALF_N)
        begin
            t = HALF_TAPS[2 * HALF_N - 1 - k];
        end
        return t;
    endfunction

endpackage

// ===== rtl/fir_decimator_by_3.sv =====
// Top level of the 3:1 FIR low-pass decimator built on a chain of delay cells.
//
// Input stream s_axis_*: one signed 16-bit sample per item in tdata.
// Output stream m_axis_*: one filtered sample per DECIMATION inputs, in tdata,
// with the saturation flag in tuser.
// Every DECIMATION-th input (first one after reset included) triggers an output
// computed from the stored samples before that input is shifted in.
// For such an item the delay chain rotates through all TAP_COUNT cells past the
// single shared multiplier, then the new sample is shifted in and the result is
// registered, which raises output tvalid. Other items are shifted in directly
// as they are accepted.
// The output register holds one result; while it is full, items that would
// produce a new output wait, other items still go in.
// Reset clears the delay cells, the phase counter and the output register.
module fir_decimator_by_3 #(
    parameter int TAP_COUNT  = 48,
    parameter int DECIMATION = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic        m_axis_tuser    // [0] clipped
);

    localparam int SW    = fird3_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(TAP_COUNT);
    localparam int PH_W  = $clog2(DECIMATION);
    localparam int ACC_W = 2 * SW + $clog2(TAP_COUNT) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_SHIFT,
        ST_FIN
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PH_W-1:0]      phase_reg;
    logic signed [SW-1:0] sample_reg;
    logic                 out_vld_reg;
    logic signed [SW-1:0] out_data_reg;
    logic                 out_clip_reg;

    logic                 in_acc;
    logic                 shift_en;
    logic signed [SW-1:0] chain_in;
    logic signed [SW-1:0] cell_q [TAP_COUNT];
    fird3_pkg::mac_ctl_t  mac_ctl;
    logic signed [SW-1:0] mac_res;
    logic                 mac_clip;
    logic signed [SW-1:0] tap;

    // Handshake
    assign s_axis_tready = (state_reg == ST_IDLE) && ((phase_reg != '0) || !out_vld_reg);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Chain control: rotate during MAC, shift in a new sample when idle or in SHIFT, hold in FIN
    always_comb
    begin
        shift_en = 1'b0;
        chain_in = sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                shift_en = in_acc && (phase_reg != '0);
                chain_in = s_axis_tdata;
            end
            ST_MAC:
            begin
                shift_en = 1'b1;
                chain_in = cell_q[0];
            end
            ST_SHIFT:
            begin
                shift_en = 1'b1;
            end
            ST_FIN:
            begin
                shift_en = 1'b0;
            end
        endcase
    end

    // Delay-line cells, index 0 holds the oldest sample
    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_cell
        logic signed [SW-1:0] d;
        if (i == TAP_COUNT - 1)
        begin : g_last
            assign d = chain_in;
        end
        else
        begin : g_mid
            assign d = cell_q[i+1];
        end
        fird3_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (shift_en),
            .d     (d),
            .q     (cell_q[i])
        );
    end

    // Multiply-accumulate on the head of the chain
    assign tap     = fird3_pkg::tap_at(32'(cnt_reg));
    assign mac_ctl = '{start: in_acc && (phase_reg == '0), mul_en: (state_reg == ST_MAC)};

    fird3_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (cell_q[0]),
        .tap    (tap),
        .result (mac_res),
        .clip   (mac_clip)
    );

    // Sequencer, phase counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= '0;
            sample_reg   <= '0;
            out_vld_reg  <= 1'b0;
            out_data_reg <= '0;
            out_clip_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (in_acc)
            begin
                phase_reg <= (phase_reg == PH_W'(DECIMATION - 1)) ? '0 : phase_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (phase_reg == '0))
                    begin
                        sample_reg <= s_axis_tdata;
                        cnt_reg    <= '0;
                        state_reg  <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    if (cnt_reg == CNT_W'(TAP_COUNT - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SHIFT:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    out_vld_reg  <= 1'b1;
                    out_data_reg <= mac_res;
                    out_clip_reg <= mac_clip;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clip_reg;

    // A new result only appears right after the finishing step
    a_rise_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("output valid rose outside the finishing step");

    // An output-producing item is never taken while the output register is full
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (phase_reg == '0)) |-> !out_vld_reg)
        else $error("item accepted with the output register still full");

    // The rotation count stays inside the chain
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (32'(cnt_reg) < TAP_COUNT))
        else $error("tap counter out of range");

    // After the sweep the new sample is shifted in exactly once
    a_shift_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && cnt_reg == CNT_W'(TAP_COUNT - 1)) |=> (state_reg == ST_SHIFT))
        else $error("shift-in step missing after the tap sweep");

endmodule

// ===== rtl/fird3_cell.sv =====
// One delay-line cell: holds a sample and takes its neighbor's value when enabled.
module fird3_cell (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic signed [fird3_pkg::SAMPLE_W-1:0]   d,
    output logic signed [fird3_pkg::SAMPLE_W-1:0]   q
);

    logic signed [fird3_pkg::SAMPLE_W-1:0] data_reg;

    // Sample storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== rtl/fird3_mac.sv =====
// Shared multiply-accumulate unit with rounding shift and int16 saturation.
module fird3_mac #(
    parameter int ACC_W = 39
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fird3_pkg::mac_ctl_t                     ctl,
    input  logic signed [fird3_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [fird3_pkg::SAMPLE_W-1:0]   tap,
    output logic signed [fird3_pkg::SAMPLE_W-1:0]   result,
    output logic                                    clip
);

    localparam int PROD_W = 2 * fird3_pkg::SAMPLE_W;
    localparam int SH_W   = ACC_W - fird3_pkg::FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SH_W-1:0]   shifted;
    logic                     over;
    logic                     under;

    // Product stage
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= sample * tap;
        end
    end

    // Accumulator stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.mul_en;
            if (ctl.start)
            begin
                acc_reg <= ACC_W'(fird3_pkg::ROUND_BIAS);
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Floor shift, then saturate to int16
    assign shifted = SH_W'(acc_reg >>> fird3_pkg::FRAC_BITS);
    assign over    = !shifted[SH_W-1] && (shifted[SH_W-2:fird3_pkg::SAMPLE_W-1] != '0);
    assign under   = shifted[SH_W-1] && (shifted[SH_W-2:fird3_pkg::SAMPLE_W-1] != '1);

    always_comb
    begin
        clip = over || under;
        if (over)
        begin
            result = 16'sh7fff;
        end
        else if (under)
        begin
            result = -16'sh8000;
        end
        else
        begin
            result = shifted[fird3_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== tb/tb_fir_decimator_by_3.sv =====
// Self-checking testbench for the 3:1 FIR decimator: directed rows, shaped random bursts.
`timescale 1ns / 1ps

module tb_fir_decimator_by_3;

    localparam int TAPS         = 48;
    localparam int PHASES       = 3;
    localparam int RANDOM_ITEMS = 826;
    localparam int TAIL_ITEMS   = 120;
    localparam int SETTLE       = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 24;

    // Low-pass taps 0..23; taps 24..47 mirror them
    localparam logic signed [15:0] LP_HALF [24] = '{
        -16'sd20,   -16'sd39,   -16'sd21,   16'sd33,    16'sd77,    16'sd45,
        -16'sd72,   -16'sd169,  -16'sd98,   16'sd145,   16'sd335,   16'sd193,
        -16'sd268,  -16'sd613,  -16'sd353,  16'sd471,   16'sd1097,  16'sd649,
        -16'sd861,  -16'sd2134, -16'sd1393, 16'sd2064,  16'sd6903,  16'sd10412
    };

    typedef struct packed {
        logic [15:0] sample;
        logic        clipped;
    } fir_out_t;

    // One directed row; a typed result is used only where want_on is set
    typedef struct packed {
        logic [15:0] din;
        logic        want_on;
        logic [15:0] want;
        logic        want_clip;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Predictor state
    logic signed [15:0] hist [TAPS];
    int unsigned        phase;

    fir_out_t    pending_out [$];
    logic        row_typed = 1'b0;
    fir_out_t    row_want = '0;
    bit          src_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned items_in = 0;
    int unsigned results_out = 0;
    int unsigned sat_high = 0;
    int unsigned sat_low = 0;

    // Onset at 32767 then zeros: first output is 0 (clear delay line), the next
    // one sees full scale only on the third-newest tap (-21), floor gives -20.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{16'h7fff, 1'b1, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b1, 16'hffec, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h5555, 1'b0, 16'h0000, 1'b0},
        '{16'haaaa, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    fir_decimator_by_3 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_fir_decimator_by_3: errors");
            $finish;
        end
    end

    function automatic logic signed [15:0] lp_tap(input int unsigned k);
        logic signed [15:0] c;
        c = 16'sd0;
        if (k < 24)
        begin
            c = LP_HALF[k];
        end
        else if (k < TAPS)
        begin
            c = LP_HALF[TAPS - 1 - k];
        end
        return c;
    endfunction

    // Decimating FIR: on phase zero, filter the stored samples, then shift in
    function automatic void fir_predict(input logic signed [15:0] x, output bit emits,
                                        output fir_out_t y);
        longint acc;
        longint q;
        emits = (phase == 0);
        y = '0;
        if (emits)
        begin
            acc = 64'sd32767;
            for (int k = 0; k < TAPS; k++)
            begin
                acc += longint'(lp_tap(k)) * longint'(hist[k]);
            end
            q = acc >>> 15;
            if (q > 32767)
            begin
                y.sample  = 16'h7fff;
                y.clipped = 1'b1;
            end
            else if (q < -32768)
            begin
                y.sample  = 16'h8000;
                y.clipped = 1'b1;
            end
            else
            begin
                y.sample = q[15:0];
            end
        end
        for (int k = 0; k < TAPS - 1; k++)
        begin
            hist[k] = hist[k + 1];
        end
        hist[TAPS - 1] = x;
        phase = (phase + 1 >= PHASES) ? 0 : phase + 1;
    endfunction

    // Check results and predict on accepted items, both at the same edge
    always @(posedge clk)
    begin : track
        fir_out_t want;
        fir_out_t pred;
        bit       emits;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out++;
                if (pending_out.size() == 0)
                begin
                    $error("unexpected result: sample_out %0d clipped %0b",
                           $signed(m_axis_tdata), m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_out.pop_front();
                    if (want.clipped && !want.sample[15])
                        sat_high++;
                    if (want.clipped && want.sample[15])
                        sat_low++;
                    if (m_axis_tdata !== want.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tuser !== want.clipped)
                    begin
                        $error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_in++;
                fir_predict(s_axis_tdata, emits, pred);
                if (emits)
                    pending_out.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // Output side back-pressure in bursts
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 7) == 0)
        begin
            hold_cnt = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one item, with an optional idle burst first, and wait for it to go in
    task automatic push_sample(input logic [15:0] din, input logic typed,
                               input fir_out_t want);
        int unsigned idle;
        @(negedge clk);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            idle = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= din;
        row_typed     <= typed;
        row_want      <= want;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned done;
        int unsigned len;
        int unsigned mode;
        int unsigned burst;
        bit          neg;
        logic [15:0] dc;
        logic [15:0] x;

        for (int k = 0; k < TAPS; k++)
            hist[k] = 16'sd0;
        phase = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, no idling on either side
        foreach (dir_rows[i])
        begin
            push_sample(dir_rows[i].din, dir_rows[i].want_on,
                        {dir_rows[i].want, dir_rows[i].want_clip});
        end
        drain_outputs();

        // Random bursts: plain random, and shaped toward saturation, DC, tiny and sparse signals
        done  = 0;
        burst = 0;
        while (done < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 5);
            len  = (mode == 2) ? $urandom_range(48, 80) : $urandom_range(12, 60);
            if (done + len > RANDOM_ITEMS)
                len = RANDOM_ITEMS - done;
            neg         = $urandom_range(0, 1);
            dc          = ($urandom_range(0, 2) == 0) ? (neg ? 16'h8000 : 16'h7fff)
                                                      : 16'($urandom);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
            begin
                if (done >= RANDOM_ITEMS - TAIL_ITEMS)
                begin
                    src_gaps    = 1'b0;
                    sink_stalls = 1'b0;
                end
                case (mode)
                    0: x = 16'($urandom);
                    1: x = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    2:
                    begin
                        // Full scale with the signs of the taps drives the sum out of range
                        if ($urandom_range(0, 15) == 0)
                            x = 16'($urandom);
                        else
                            x = ((lp_tap(i % TAPS) >= 0) ^ neg) ? 16'h7fff : 16'h8000;
                    end
                    3: x = dc;
                    4: x = 16'($urandom_range(0, 16)) - 16'd8;
                    default: x = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
                endcase
                push_sample(x, 1'b0, '0);
                done++;
            end
            burst++;
            if (burst == 7)
                drain_outputs();
        end

        // Wind down
        sink_stalls = 1'b0;
        drain_outputs();
        repeat (SETTLE) @(posedge clk);

        $display("run covered %0d samples in and %0d filtered samples out", items_in,
                 results_out);
        $display("saturation seen %0d times high and %0d times low", sat_high, sat_low);
        if (errors == 0)
        begin
            $display("tb_fir_decimator_by_3: clean");
        end
        else
        begin
            $display("tb_fir_decimator_by_3: errors");
        end
        $finish;
    end

endmodule
